// ===== src/cse_pkg.sv =====
package cse_pkg;

    localparam int ANGLE_W   = 16;
    localparam int COS_W     = 32;
    localparam int SQ_W      = 32;
    localparam int TERM_W    = 48;
    localparam int HALF_W    = 24;
    localparam int PROD_W    = HALF_W + SQ_W;
    localparam int IDX_W     = 4;
    localparam int DIV_W     = 10;
    localparam int OUT_SHIFT = 12;

    localparam int MAX_TERMS_DEF = 15;

    localparam logic [IDX_W-1:0]  TERM_COUNT_RESET = 4'd7;
    localparam logic [TERM_W-1:0] TERM_ONE         = 48'h0001_0000_0000;

    // Divisor (2i-1)*2i that turns term i-1 into term i
    function automatic logic [DIV_W-1:0] term_divisor(input logic [IDX_W-1:0] idx);
        logic [DIV_W-1:0] d;
        case (idx)
            4'd1:    d = 10'd2;
            4'd2:    d = 10'd12;
            4'd3:    d = 10'd30;
            4'd4:    d = 10'd56;
            4'd5:    d = 10'd90;
            4'd6:    d = 10'd132;
            4'd7:    d = 10'd182;
            4'd8:    d = 10'd240;
            4'd9:    d = 10'd306;
            4'd10:   d = 10'd380;
            4'd11:   d = 10'd462;
            4'd12:   d = 10'd552;
            4'd13:   d = 10'd650;
            4'd14:   d = 10'd756;
            4'd15:   d = 10'd870;
            default: d = 10'd1;
        endcase
        return d;
    endfunction

endpackage

// ===== src/cosine_series_evaluator_top.sv =====
// Each item runs N terms from input transfer to result valid, N the clamped term count.
// Each term waits on the shared 24x32 multiplier (two partial products), then on the
// bit-serial 48-bit divider, and then passes through sequencing and summing.
// A new angle is taken only once the sequencer is idle; a result still waiting holds the sequencer.
// Reset (synchronous, active low) clears the sequencer and output valid and sets the
// term count register to 7.
module cosine_series_evaluator_top #(
    parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [15:0]                 i_s_axis_tdata,   // [15:0] angle
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,   // [31:0] cosine
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cse_pkg::IDX_W-1:0]   i_cfg_data        // term_count
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL_GO   = 8'b0000_0010,
        S_MUL_WAIT = 8'b0000_0100,
        S_DIV_GO   = 8'b0000_1000,
        S_DIV_WAIT = 8'b0001_0000,
        S_TERM     = 8'b0010_0000,
        S_SUM      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    localparam int SHIFT_W = cse_pkg::TERM_W - cse_pkg::OUT_SHIFT;

    t_state                          r_state, n_state;
    logic [cse_pkg::IDX_W-1:0]       r_tc;
    logic [cse_pkg::IDX_W-1:0]       r_n;
    logic [cse_pkg::IDX_W-1:0]       r_idx;
    logic [cse_pkg::SQ_W-1:0]        r_sq;
    logic [cse_pkg::TERM_W-1:0]      r_term;
    logic [cse_pkg::TERM_W-1:0]      r_sum;
    logic                            r_out_valid;
    logic [cse_pkg::COS_W-1:0]       r_out;

    logic                            w_in_xfer;
    logic [cse_pkg::ANGLE_W-1:0]     w_ax;
    logic [cse_pkg::IDX_W-1:0]       w_n;
    logic                            w_out_free;
    logic                            w_mul_done;
    logic [cse_pkg::TERM_W-1:0]      w_mul_prod;
    logic                            w_div_done;
    logic [cse_pkg::TERM_W-1:0]      w_quot;
    logic                            w_div_neg;
    logic [SHIFT_W-1:0]              w_shift;
    logic [cse_pkg::COS_W-1:0]       w_sat;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_ax = i_s_axis_tdata[cse_pkg::ANGLE_W-1] ? -i_s_axis_tdata : i_s_axis_tdata;
    assign w_n  = (r_tc > cse_pkg::IDX_W'(MAX_TERMS)) ? cse_pkg::IDX_W'(MAX_TERMS) : r_tc;

    // Floor of sum / 2^12, then clamp to 32 signed bits
    assign w_shift = r_sum[cse_pkg::TERM_W-1:cse_pkg::OUT_SHIFT];
    always_comb begin
        if (w_shift[SHIFT_W-1:cse_pkg::COS_W-1] == '0 ||
            w_shift[SHIFT_W-1:cse_pkg::COS_W-1] == '1) begin
            w_sat = w_shift[cse_pkg::COS_W-1:0];
        end else if (w_shift[SHIFT_W-1]) begin
            w_sat = {1'b1, {(cse_pkg::COS_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(cse_pkg::COS_W-1){1'b1}}};
        end
    end

    cse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL_GO),
        .i_term  (r_term),
        .i_sq    (r_sq),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    cse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV_GO),
        .i_dividend (w_mul_prod),
        .i_divisor  (cse_pkg::term_divisor(r_idx)),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_neg      (w_div_neg)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (w_n == '0) ? S_DONE : S_MUL_GO;
                end
            end
            S_MUL_GO:   n_state = S_MUL_WAIT;
            S_MUL_WAIT: if (w_mul_done) n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (w_div_done) n_state = S_TERM;
            S_TERM:     n_state = S_SUM;
            S_SUM:      n_state = (r_idx == r_n) ? S_DONE : S_MUL_GO;
            S_DONE:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tc        <= cse_pkg::TERM_COUNT_RESET;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tc <= i_cfg_data;
            end
            if (w_in_xfer) begin
                r_idx <= '0;
            end else if (r_state == S_MUL_GO) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sq   <= cse_pkg::SQ_W'(w_ax) * cse_pkg::SQ_W'(w_ax);
            r_term <= cse_pkg::TERM_ONE;
            r_sum  <= cse_pkg::TERM_ONE;
            r_n    <= w_n;
        end
        // the new term takes the sign opposite to the shifted product
        if (r_state == S_TERM) begin
            r_term <= w_div_neg ? w_quot : -w_quot;
        end
        if (r_state == S_SUM) begin
            r_sum <= r_sum + r_term;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out <= w_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    a_mul_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == S_MUL_WAIT)
        else $error("multiplier finished outside its wait state");

    a_div_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_WAIT || r_state == S_DIV_GO || r_state == S_DIV_WAIT ||
         r_state == S_TERM || r_state == S_SUM) |-> (r_idx <= r_n && r_idx != '0))
        else $error("term index out of range");

    a_last_term_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_idx == r_n) |=> r_state == S_DONE)
        else $error("sequencer missed the last term");

endmodule

// ===== src/cse_mul.sv =====
module cse_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cse_pkg::TERM_W-1:0]     i_term,
    input  logic [cse_pkg::SQ_W-1:0]       i_sq,
    output logic                           o_done,
    output logic [cse_pkg::TERM_W-1:0]     o_prod
);

    typedef enum logic [2:0] {
        PH_LO  = 3'b001,
        PH_HI  = 3'b010,
        PH_NEG = 3'b100
    } t_mul_ph;

    t_mul_ph                         r_phase;
    logic                            r_busy;
    logic                            r_done;
    logic [cse_pkg::TERM_W-1:0]      r_m;
    logic                            r_neg;
    logic [cse_pkg::SQ_W-1:0]        r_sq;
    logic [cse_pkg::PROD_W-1:0]      r_p;
    logic [cse_pkg::TERM_W-1:0]      r_q;
    logic                            r_sticky;
    logic [cse_pkg::TERM_W-1:0]      r_v;

    logic [cse_pkg::HALF_W-1:0]      w_a;
    logic [cse_pkg::PROD_W-1:0]      w_prod;

    // One 24x32 multiplier serves both halves of the magnitude
    assign w_a    = (r_phase == PH_LO) ? r_m[cse_pkg::HALF_W-1:0]
                                       : r_m[cse_pkg::TERM_W-1:cse_pkg::HALF_W];
    assign w_prod = cse_pkg::PROD_W'(w_a) * cse_pkg::PROD_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_LO;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= PH_LO;
            end else if (r_busy) begin
                case (r_phase)
                    PH_LO:   r_phase <= PH_HI;
                    PH_HI:   r_phase <= PH_NEG;
                    PH_NEG: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    default: r_phase <= PH_LO;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= i_term[cse_pkg::TERM_W-1] ? -i_term : i_term;
            r_neg <= i_term[cse_pkg::TERM_W-1];
            r_sq  <= i_sq;
        end else if (r_busy) begin
            case (r_phase)
                PH_LO:   r_p <= w_prod;
                PH_HI: begin
                    r_q      <= w_prod[cse_pkg::TERM_W-1:0]
                              + cse_pkg::TERM_W'(r_p[cse_pkg::PROD_W-1:cse_pkg::HALF_W]);
                    r_sticky <= |r_p[cse_pkg::HALF_W-1:0];
                end
                // a negative product rounds toward minus infinity
                PH_NEG:  r_v <= r_neg ? -(r_q + cse_pkg::TERM_W'(r_sticky)) : r_q;
                default: r_v <= r_q;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_v;

endmodule

// ===== src/cse_div.sv =====
module cse_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cse_pkg::TERM_W-1:0]     i_dividend,
    input  logic [cse_pkg::DIV_W-1:0]      i_divisor,
    output logic                           o_done,
    output logic [cse_pkg::TERM_W-1:0]     o_quot,
    output logic                           o_neg
);

    localparam int CNT_W = $clog2(cse_pkg::TERM_W);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [cse_pkg::TERM_W-1:0]      r_num;
    logic [cse_pkg::DIV_W-1:0]       r_rem;
    logic [cse_pkg::DIV_W-1:0]       r_d;
    logic                            r_neg;

    logic [cse_pkg::DIV_W:0]         w_trial;
    logic                            w_ge;
    logic [cse_pkg::DIV_W:0]         w_diff;

    // Restoring division, one quotient bit a cycle shifted in behind the dividend
    assign w_trial = {r_rem, r_num[cse_pkg::TERM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(cse_pkg::TERM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend[cse_pkg::TERM_W-1] ? -i_dividend : i_dividend;
            r_neg <= i_dividend[cse_pkg::TERM_W-1];
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[cse_pkg::TERM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[cse_pkg::DIV_W-1:0] : w_trial[cse_pkg::DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_neg  = r_neg;

endmodule
